>>> rtl/vfrc_pkg.sv
// shared types and constants for the display frame refresh controller
// no dependencies; used by vfrc_store and vfd_frame_refresh_controller
package vfrc_pkg;

  localparam int unsigned STORE_AW = 10;
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;
  localparam int unsigned POS_W = STORE_AW + 1;
  localparam int unsigned COL_W = 7;
  localparam int unsigned PAGE_SHIFT = 7;

  localparam logic [2:0] CMD_POLL = 3'd0;
  localparam logic [2:0] CMD_BLINK = 3'd1;
  localparam logic [2:0] CMD_FRAME = 3'd2;
  localparam logic [2:0] CMD_GRID = 3'd3;
  localparam logic [2:0] CMD_BAT_MODE = 3'd4;
  localparam logic [2:0] CMD_WATER_MODE = 3'd5;
  localparam logic [2:0] CMD_BAT_LEVEL = 3'd6;
  localparam logic [2:0] CMD_WATER_LEVEL = 3'd7;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_ON = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;
  localparam logic [1:0] MODE_ALT_ON = 2'd3;

  localparam logic [3:0] LEVEL_MAX = 4'd8;
  localparam logic [7:0] BAT_BAR = 8'hF0;
  localparam logic [15:0] WATER_BAR = 16'hFF00;

  localparam int unsigned GAUGE_COL = 70;
  localparam int unsigned BAT_ON_OFS = 5;
  localparam int unsigned BAT_LEVEL_OFS = 1;

  typedef struct packed {
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
  } store_req_t;

endpackage

>>> rtl/vfrc_store.sv
// frame store: single write port, single read port with registered read data
// depends on vfrc_pkg for the request struct and depth
module vfrc_store
  import vfrc_pkg::*;
(
  input  logic       clk,
  input  store_req_t req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/vfd_frame_refresh_controller.sv
// top level of the display frame refresh controller
// depends on vfrc_pkg and vfrc_store
//
//   channel   handshake          payload
//   input     start / busy       in_command, in_panel_busy, in_pixel_*, in_status_value, in_level
//   result    out_valid          out_write_strobe, out_bus_address, out_bus_data, out_*_lamp
//
// an item is taken when start is high and busy is low; its result shows on the cycle after acceptance,
// one item per cycle sustained while busy is low (at most one frame store access per item)
// after reset the frame store is zeroed one entry a cycle: busy stays high until
// every entry is cleared, and no item is taken before that
// results cannot be stalled; each is valid for exactly one cycle
module vfd_frame_refresh_controller
  import vfrc_pkg::*;
#(
  parameter int unsigned PAGES = 8,
  parameter int unsigned VISIBLE_COLS = 127
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             in_command,
  input  logic                   in_panel_busy,
  input  logic [9:0]             in_pixel_index,
  input  logic [7:0]             in_pixel_value,
  input  logic                   in_pixel_last,
  input  logic [1:0]             in_status_value,
  input  logic [3:0]             in_level,
  output logic                   out_valid,
  output logic                   out_write_strobe,
  output logic [9:0]             out_bus_address,
  output logic [7:0]             out_bus_data,
  output logic                   out_grid_lamp,
  output logic                   out_water_lamp
);

  localparam int unsigned PAGE_W = $clog2(PAGES);
  localparam int unsigned SCAN_END = PAGES * (VISIBLE_COLS + 1);
  localparam int unsigned LOAD_END = PAGES * VISIBLE_COLS;
  localparam int unsigned WATER_ENTRY = PAGES * GAUGE_COL;
  localparam int unsigned BAT_LEVEL_ENTRY = WATER_ENTRY + BAT_LEVEL_OFS;
  localparam int unsigned BAT_ON_ENTRY = WATER_ENTRY + BAT_ON_OFS;

  localparam logic [POS_W-1:0] SCAN_END_P = POS_W'(SCAN_END);
  localparam logic [POS_W-1:0] LOAD_END_P = POS_W'(LOAD_END);
  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PAGES - 1);

  localparam logic [POS_W-1:0] WATER_POS = POS_W'(WATER_ENTRY);
  localparam logic [COL_W-1:0] WATER_COL = COL_W'(WATER_ENTRY / PAGES);
  localparam logic [PAGE_W-1:0] WATER_PAGE = PAGE_W'(WATER_ENTRY % PAGES);
  localparam logic [POS_W-1:0] BLVL_POS = POS_W'(BAT_LEVEL_ENTRY);
  localparam logic [COL_W-1:0] BLVL_COL = COL_W'(BAT_LEVEL_ENTRY / PAGES);
  localparam logic [PAGE_W-1:0] BLVL_PAGE = PAGE_W'(BAT_LEVEL_ENTRY % PAGES);
  localparam logic [POS_W-1:0] BON_POS = POS_W'(BAT_ON_ENTRY);
  localparam logic [COL_W-1:0] BON_COL = COL_W'(BAT_ON_ENTRY / PAGES);
  localparam logic [PAGE_W-1:0] BON_PAGE = PAGE_W'(BAT_ON_ENTRY % PAGES);

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [1:0]          grid_mode_r, grid_mode_nxt;
  logic [1:0]          bat_mode_r, bat_mode_nxt;
  logic [1:0]          water_mode_r, water_mode_nxt;
  logic                phase_r, phase_nxt;
  logic                grid_pin_r, grid_pin_nxt;
  logic                water_pin_r, water_pin_nxt;
  logic                clearing_r, clearing_nxt;
  logic [STORE_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                valid_r, valid_nxt;
  logic                wstrobe_r, wstrobe_nxt;
  logic [9:0]          addr_r, addr_nxt;

  logic                accept;
  logic [1:0]          mode;
  logic [3:0]          lvl;
  logic [15:0]         water_bar;
  logic                rw_en;
  logic [POS_W-1:0]    rw_pos;
  logic [COL_W-1:0]    rw_col;
  logic [PAGE_W-1:0]   rw_page;
  store_req_t          req;
  logic [7:0]          rd_data;

  vfrc_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  assign accept = start && !clearing_r;
  assign mode = (in_status_value == MODE_ALT_ON) ? MODE_ON : in_status_value;
  assign lvl = (in_level > LEVEL_MAX) ? LEVEL_MAX : in_level;
  assign water_bar = WATER_BAR >> lvl;

  always_comb begin
    pos_nxt = pos_r;
    col_nxt = col_r;
    page_nxt = page_r;
    grid_mode_nxt = grid_mode_r;
    bat_mode_nxt = bat_mode_r;
    water_mode_nxt = water_mode_r;
    phase_nxt = phase_r;
    grid_pin_nxt = grid_pin_r;
    water_pin_nxt = water_pin_r;
    clearing_nxt = clearing_r;
    clr_cnt_nxt = clr_cnt_r;
    valid_nxt = 1'b0;
    wstrobe_nxt = 1'b0;
    addr_nxt = '0;
    rw_en = 1'b0;
    rw_pos = '0;
    rw_col = '0;
    rw_page = '0;
    req = '0;

    if (clearing_r) begin
      req.wr_en = 1'b1;
      req.wr_addr = clr_cnt_r;
      req.wr_data = 8'h00;
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == {STORE_AW{1'b1}}) begin
        clearing_nxt = 1'b0;
      end
    end else if (accept) begin
      valid_nxt = 1'b1;
      unique case (in_command)
        CMD_POLL: begin
          if (pos_r < SCAN_END_P && !in_panel_busy) begin
            req.rd_en = 1'b1;
            req.rd_addr = pos_r[STORE_AW-1:0];
            wstrobe_nxt = 1'b1;
            addr_nxt = (10'(page_r) << PAGE_SHIFT) | 10'(col_r);
            pos_nxt = pos_r + 1'b1;
            if (page_r == PAGE_LAST) begin
              page_nxt = '0;
              col_nxt = col_r + 1'b1;
            end else begin
              page_nxt = page_r + 1'b1;
            end
          end
        end
        CMD_BLINK: begin
          if (grid_mode_r == MODE_BLINK) begin
            grid_pin_nxt = phase_r;
          end
          if (water_mode_r == MODE_BLINK) begin
            water_pin_nxt = phase_r;
          end
          if (bat_mode_r == MODE_BLINK) begin
            req.wr_en = 1'b1;
            req.wr_addr = BON_POS[STORE_AW-1:0];
            req.wr_data = {7'd0, phase_r};
            rw_en = 1'b1;
            rw_pos = BON_POS;
            rw_col = BON_COL;
            rw_page = BON_PAGE;
          end
          phase_nxt = !phase_r;
        end
        CMD_FRAME: begin
          if (POS_W'(in_pixel_index) < LOAD_END_P) begin
            req.wr_en = 1'b1;
            req.wr_addr = in_pixel_index;
            req.wr_data = in_pixel_value;
          end
          // last byte of a load restarts the scan from the top
          rw_en = in_pixel_last;
        end
        CMD_GRID: begin
          if (mode != MODE_BLINK) begin
            grid_pin_nxt = mode[0];
          end
          grid_mode_nxt = mode;
        end
        CMD_BAT_MODE: begin
          if (mode != MODE_BLINK) begin
            req.wr_en = 1'b1;
            req.wr_addr = BON_POS[STORE_AW-1:0];
            req.wr_data = {7'd0, mode[0]};
            rw_en = 1'b1;
            rw_pos = BON_POS;
            rw_col = BON_COL;
            rw_page = BON_PAGE;
          end
          bat_mode_nxt = mode;
        end
        CMD_WATER_MODE: begin
          if (mode != MODE_BLINK) begin
            water_pin_nxt = mode[0];
          end
          water_mode_nxt = mode;
        end
        CMD_BAT_LEVEL: begin
          req.wr_en = 1'b1;
          req.wr_addr = BLVL_POS[STORE_AW-1:0];
          req.wr_data = BAT_BAR >> lvl;
          rw_en = 1'b1;
          rw_pos = BLVL_POS;
          rw_col = BLVL_COL;
          rw_page = BLVL_PAGE;
        end
        CMD_WATER_LEVEL: begin
          req.wr_en = 1'b1;
          req.wr_addr = WATER_POS[STORE_AW-1:0];
          req.wr_data = water_bar[7:0];
          rw_en = 1'b1;
          rw_pos = WATER_POS;
          rw_col = WATER_COL;
          rw_page = WATER_PAGE;
        end
        default: begin
        end
      endcase

      // pull the scan back so a changed entry is sent again
      if (rw_en && pos_r > rw_pos) begin
        pos_nxt = rw_pos;
        col_nxt = rw_col;
        page_nxt = rw_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      col_r <= '0;
      page_r <= '0;
      grid_mode_r <= MODE_OFF;
      bat_mode_r <= MODE_OFF;
      water_mode_r <= MODE_OFF;
      phase_r <= 1'b0;
      grid_pin_r <= 1'b0;
      water_pin_r <= 1'b0;
      clearing_r <= 1'b1;
      clr_cnt_r <= '0;
      valid_r <= 1'b0;
      wstrobe_r <= 1'b0;
      addr_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      col_r <= col_nxt;
      page_r <= page_nxt;
      grid_mode_r <= grid_mode_nxt;
      bat_mode_r <= bat_mode_nxt;
      water_mode_r <= water_mode_nxt;
      phase_r <= phase_nxt;
      grid_pin_r <= grid_pin_nxt;
      water_pin_r <= water_pin_nxt;
      clearing_r <= clearing_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      valid_r <= valid_nxt;
      wstrobe_r <= wstrobe_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign busy = clearing_r;
  assign out_valid = valid_r;
  assign out_write_strobe = wstrobe_r;
  assign out_bus_address = addr_r;
  assign out_bus_data = wstrobe_r ? rd_data : 8'h00;
  assign out_grid_lamp = grid_pin_r;
  assign out_water_lamp = water_pin_r;

endmodule
